// ----- hw/rtl/ansi_terminal_cursor_engine_macros.svh -----
// Assertion macros shared by the cursor engine modules.
`ifndef ANSI_TERMINAL_CURSOR_ENGINE_MACROS_SVH
`define ANSI_TERMINAL_CURSOR_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled while in reset
`define ATCE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication, disabled while in reset
`define ATCE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ATCE_ASSERT_NOW(lbl, ante, cons)
`define ATCE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- hw/rtl/atce_pkg.sv -----
// Shared constants and types of the terminal cursor engine.
package atce_pkg;

  localparam int COLUMNS     = 40;
  localparam int ROWS        = 28;
  localparam int MAX_PARAMS  = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // console byte codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_CTRL_A = 8'h01;
  localparam logic [7:0] CH_CTRL_B = 8'h02;
  localparam logic [7:0] CH_CTRL_E = 8'h05;
  localparam logic [7:0] CH_CTRL_F = 8'h06;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_CAN    = 8'h18;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_F      = 8'h46;
  localparam logic [7:0] CH_H      = 8'h48;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_O      = 8'h4F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_TILDE  = 8'h7E;

  // first CSI parameter values that '~' acts on
  localparam logic [15:0] KEY_HOME_A = 16'd1;
  localparam logic [15:0] KEY_DELETE = 16'd3;
  localparam logic [15:0] KEY_END_A  = 16'd4;
  localparam logic [15:0] KEY_HOME_B = 16'd7;
  localparam logic [15:0] KEY_END_B  = 16'd8;

  typedef enum logic [1:0] {
    EV_DRAW    = 2'd0,
    EV_NEW_ROW = 2'd1,
    EV_SCROLL  = 2'd2
  } atce_event_t;

  // one decoded character: what the back end still has to emit
  typedef struct packed {
    logic       draw;
    logic [5:0] draw_col;
    logic [4:0] draw_row;
    logic [7:0] glyph;
    logic       new_row;
    logic       scroll;
    logic [4:0] row;
  } atce_action_t;

endpackage

// ----- hw/rtl/atce_front.sv -----
// Front end: escape parser, cursor tracking and action decode.
module atce_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,
  input  logic                  q_full,
  output logic                  q_push,
  output atce_pkg::atce_action_t q_action
);

  typedef enum logic [2:0] {
    MODE_PLAIN = 3'd0,
    MODE_ESC   = 3'd1,
    MODE_SS2   = 3'd2,
    MODE_SS3   = 3'd3,
    MODE_CSI   = 3'd4
  } mode_t;

  localparam logic [7:0]  COL_HOME = 8'd1;
  localparam logic [7:0]  COL_END  = 8'(atce_pkg::COLUMNS - 1);
  localparam logic [7:0]  COL_LIM  = 8'(atce_pkg::COLUMNS);
  localparam logic [5:0]  ROW_LIM  = 6'(atce_pkg::ROWS);
  localparam logic [4:0]  ROW_LAST = 5'(atce_pkg::ROWS - 1);
  localparam logic [3:0]  PC_MAX   = 4'(atce_pkg::MAX_PARAMS);

  mode_t       mode_r, mode_nxt;
  logic [7:0]  cursor_col_r, cursor_col_nxt;
  logic [4:0]  cursor_row_r, cursor_row_nxt;
  logic [15:0] first_param_r, first_param_nxt;
  logic [2:0]  param_count_r, param_count_nxt;

  logic        accept, live;
  logic [7:0]  ch, col_mid, draw_col8;
  logic        draw, row_inc, overflow, scroll, draw_ok;
  logic [5:0]  row_sum;
  logic [3:0]  digit, pc_inc;
  logic [15:0] fp_mac;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign ch        = in_tdata;
  assign live      = accept && (ch != atce_pkg::CH_NUL);

  assign digit  = 4'(ch - atce_pkg::CH_ZERO);
  assign fp_mac = (first_param_r << 3) + (first_param_r << 1) + {12'd0, digit};
  assign pc_inc = {1'b0, param_count_r} + 4'd1;

  always_comb begin
    mode_nxt        = mode_r;
    col_mid         = cursor_col_r;
    first_param_nxt = first_param_r;
    param_count_nxt = param_count_r;
    draw            = 1'b0;
    draw_col8       = cursor_col_r;
    row_inc         = 1'b0;
    if (ch == atce_pkg::CH_CAN) begin
      mode_nxt = MODE_PLAIN;
    end else begin
      unique case (mode_r)
        MODE_PLAIN: begin
          if (ch == atce_pkg::CH_CR) begin
            col_mid = COL_HOME;
            row_inc = 1'b1;
          end else if (ch == atce_pkg::CH_ESC) begin
            mode_nxt = MODE_ESC;
          end else if (ch == atce_pkg::CH_BS || ch == atce_pkg::CH_DEL ||
                       ch == atce_pkg::CH_CTRL_B) begin
            col_mid   = cursor_col_r - 8'd1;
            draw_col8 = cursor_col_r - 8'd1;
            draw      = 1'b1;
          end else if (ch == atce_pkg::CH_CTRL_A) begin
            col_mid = COL_HOME;
          end else if (ch == atce_pkg::CH_CTRL_E) begin
            col_mid = COL_END;
          end else if (ch == atce_pkg::CH_CTRL_F) begin
            col_mid = cursor_col_r + 8'd1;
          end else if (ch >= atce_pkg::CH_SPACE) begin
            draw    = 1'b1;
            col_mid = cursor_col_r + 8'd1;
          end
        end
        MODE_ESC: begin
          if (ch == atce_pkg::CH_LBRACK) begin
            mode_nxt        = MODE_CSI;
            param_count_nxt = 3'd0;
            first_param_nxt = 16'd0;
          end else if (ch == atce_pkg::CH_N) begin
            mode_nxt = MODE_SS2;
          end else if (ch == atce_pkg::CH_O) begin
            mode_nxt = MODE_SS3;
          end else begin
            mode_nxt = MODE_PLAIN;
            if (ch == atce_pkg::CH_DEL) begin
              col_mid   = cursor_col_r - 8'd1;
              draw_col8 = cursor_col_r - 8'd1;
              draw      = 1'b1;
            end
          end
        end
        MODE_SS2: begin
          mode_nxt = MODE_PLAIN;
        end
        MODE_SS3: begin
          mode_nxt = MODE_PLAIN;
          if (ch == atce_pkg::CH_F) col_mid = COL_END;
          else if (ch == atce_pkg::CH_H) col_mid = COL_HOME;
        end
        MODE_CSI: begin
          if (ch >= atce_pkg::CH_ZERO && ch <= atce_pkg::CH_NINE) begin
            if (param_count_r == 3'd0) first_param_nxt = fp_mac;
          end else begin
            param_count_nxt = (pc_inc > PC_MAX) ? PC_MAX[2:0] : pc_inc[2:0];
            if (ch != atce_pkg::CH_SEMI && ch != atce_pkg::CH_COLON) begin
              mode_nxt = MODE_PLAIN;
              if (ch == atce_pkg::CH_C) begin
                col_mid = cursor_col_r + 8'd1;
              end else if (ch == atce_pkg::CH_D) begin
                col_mid = cursor_col_r - 8'd1;
              end else if (ch == atce_pkg::CH_F) begin
                col_mid = COL_END;
              end else if (ch == atce_pkg::CH_H) begin
                col_mid = 8'd0;
              end else if (ch == atce_pkg::CH_TILDE) begin
                if (first_param_r == atce_pkg::KEY_HOME_A ||
                    first_param_r == atce_pkg::KEY_HOME_B)
                  col_mid = COL_HOME;
                else if (first_param_r == atce_pkg::KEY_END_A ||
                         first_param_r == atce_pkg::KEY_END_B)
                  col_mid = COL_END;
                else if (first_param_r == atce_pkg::KEY_DELETE)
                  col_mid = cursor_col_r - 8'd1;
              end
            end
          end
        end
        default: begin
          mode_nxt = MODE_PLAIN;
        end
      endcase
    end
  end

  // column overflow wraps to the next row; passing the last row scrolls
  assign overflow       = col_mid >= COL_LIM;
  assign cursor_col_nxt = overflow ? COL_HOME : col_mid;
  assign row_sum        = {1'b0, cursor_row_r} + {5'd0, row_inc} + {5'd0, overflow};
  assign scroll         = row_sum >= ROW_LIM;
  assign cursor_row_nxt = scroll ? ROW_LAST : row_sum[4:0];
  assign draw_ok        = draw && (draw_col8 < COL_LIM);

  always_comb begin
    q_action          = '0;
    q_action.draw     = draw_ok;
    q_action.draw_col = draw_col8[5:0];
    q_action.draw_row = cursor_row_r;
    q_action.glyph    = (ch >= atce_pkg::CH_SPACE && ch != atce_pkg::CH_DEL &&
                         mode_r == MODE_PLAIN) ? ch : atce_pkg::CH_SPACE;
    q_action.new_row  = row_inc || overflow;
    q_action.scroll   = scroll;
    q_action.row      = cursor_row_nxt;
  end

  assign q_push = live && (draw_ok || row_inc || overflow || scroll);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_PLAIN;
      cursor_col_r  <= COL_HOME;
      cursor_row_r  <= 5'd0;
      first_param_r <= 16'd0;
      param_count_r <= 3'd0;
    end else if (live) begin
      mode_r        <= mode_nxt;
      cursor_col_r  <= cursor_col_nxt;
      cursor_row_r  <= cursor_row_nxt;
      first_param_r <= first_param_nxt;
      param_count_r <= param_count_nxt;
    end
  end

`include "ansi_terminal_cursor_engine_macros.svh"
  `ATCE_ASSERT_NOW(a_front_row_range, 1'b1, {1'b0, cursor_row_r} < ROW_LIM)
  `ATCE_ASSERT_NOW(a_front_col_range, 1'b1, cursor_col_r < COL_LIM)

endmodule

// ----- hw/rtl/atce_queue.sv -----
// Short action queue between the front and back ends.
module atce_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  atce_pkg::atce_action_t push_data,
  output logic                   full,
  input  logic                   pop,
  output logic                   head_valid,
  output atce_pkg::atce_action_t head_data
);

  localparam int AW = atce_pkg::QUEUE_AW;
  localparam int CW = atce_pkg::QUEUE_CW;

  atce_pkg::atce_action_t store_r [atce_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full       = count_r == CW'(atce_pkg::QUEUE_DEPTH);
  assign head_valid = count_r != '0;
  assign head_data  = store_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + CW'(1);
    else if (do_pop && !do_push) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) store_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + AW'(1);
      if (do_pop) rd_ptr_r <= rd_ptr_r + AW'(1);
      count_r <= count_nxt;
    end
  end

`include "ansi_terminal_cursor_engine_macros.svh"
  `ATCE_ASSERT_NOW(a_queue_no_overrun, push, !full)

endmodule

// ----- hw/rtl/atce_back.sv -----
// Back end: expands queued actions into output words.
module atce_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  atce_pkg::atce_action_t q_action,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [1:0]             out_kind,
  output logic [5:0]             out_col,
  output logic [4:0]             out_row,
  output logic [7:0]             out_glyph,
  output logic                   out_last
);

  atce_pkg::atce_action_t cur_r;
  logic                   cur_valid_r;
  logic                   pend_draw_r, pend_row_r, pend_scroll_r;
  logic                   out_valid_r;
  atce_pkg::atce_event_t  kind_r, kind_nxt;
  logic [5:0]             col_r, col_nxt;
  logic [4:0]             row_r, row_nxt;
  logic [7:0]             glyph_r, glyph_nxt;
  logic                   last_r, last_nxt;
  logic                   adv, load;
  logic                   left_draw, left_row, left_scroll;

  assign adv = cur_valid_r && (!out_valid_r || out_tready);

  // pick the oldest pending event: draw, then new row, then scroll
  always_comb begin
    left_draw   = pend_draw_r;
    left_row    = pend_row_r;
    left_scroll = pend_scroll_r;
    kind_nxt    = atce_pkg::EV_SCROLL;
    col_nxt     = 6'd0;
    row_nxt     = cur_r.row;
    glyph_nxt   = 8'd0;
    if (pend_draw_r) begin
      kind_nxt  = atce_pkg::EV_DRAW;
      col_nxt   = cur_r.draw_col;
      row_nxt   = cur_r.draw_row;
      glyph_nxt = cur_r.glyph;
      left_draw = 1'b0;
    end else if (pend_row_r) begin
      kind_nxt = atce_pkg::EV_NEW_ROW;
      left_row = 1'b0;
    end else begin
      left_scroll = 1'b0;
    end
    last_nxt = !(left_draw || left_row || left_scroll);
  end

  assign load  = q_valid && (!cur_valid_r || (adv && last_nxt));
  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r   <= 1'b0;
      pend_draw_r   <= 1'b0;
      pend_row_r    <= 1'b0;
      pend_scroll_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (load) begin
        cur_valid_r   <= 1'b1;
        pend_draw_r   <= q_action.draw;
        pend_row_r    <= q_action.new_row;
        pend_scroll_r <= q_action.scroll;
      end else if (adv) begin
        cur_valid_r   <= !last_nxt;
        pend_draw_r   <= left_draw;
        pend_row_r    <= left_row;
        pend_scroll_r <= left_scroll;
      end
      if (adv) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) cur_r <= q_action;
    if (adv) begin
      kind_r  <= kind_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      glyph_r <= glyph_nxt;
      last_r  <= last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_kind   = kind_r;
  assign out_col    = col_r;
  assign out_row    = row_r;
  assign out_glyph  = glyph_r;
  assign out_last   = last_r;

`include "ansi_terminal_cursor_engine_macros.svh"
  `ATCE_ASSERT_NOW(a_back_scroll_last, out_valid_r && kind_r == atce_pkg::EV_SCROLL, last_r)
  `ATCE_ASSERT_NOW(a_back_draw_onscreen, out_valid_r && kind_r == atce_pkg::EV_DRAW,
                   {2'b00, col_r} < 8'(atce_pkg::COLUMNS))

endmodule

// ----- hw/rtl/ansi_terminal_cursor_engine.sv -----
// Top level of the terminal cursor engine: front end, action queue, back end.
//
// Use: in_* carries one console byte per word (in_tdata). out_* carries
// screen commands: out_tuser is the event kind (draw cell, new row,
// scroll up), out_tdata the cell column, row and glyph, and out_tlast
// marks the final word caused by one input byte. A byte yields zero to
// three words, always in the order draw, new row, scroll.
// The first word of a byte passes through the action queue, the back
// end's current-action register and its output register. Throughput:
// one input byte per cycle while the action queue has room; the back
// end emits one output word per cycle while the receiver takes them,
// and a byte that only changes the parser or cursor yields no words.
// The front end decodes each byte in the cycle it is taken and keeps the
// cursor and parser state; a four-entry queue holds decoded actions.
// Reset (rst_n low, synchronous) puts the cursor at column 1, row 0,
// returns the parser to plain mode and empties queue and output register.
// When the receiver stalls, the output word holds, the queue fills and
// in_tready drops once it is full.
module ansi_terminal_cursor_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] character
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [5:0] cell_column, [10:6] cell_row,
                                  // [18:11] glyph, [23:19] zero
  output logic [1:0]  out_tuser,  // [1:0] event_kind
  output logic        out_tlast   // last_event
);

  atce_pkg::atce_action_t push_action, head_action;
  logic                   q_full, q_push, q_pop, q_valid;
  logic [5:0]             ev_col;
  logic [4:0]             ev_row;
  logic [7:0]             ev_glyph;

  atce_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_action  (push_action)
  );

  atce_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (push_action),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (head_action)
  );

  atce_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_action   (head_action),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_kind   (out_tuser),
    .out_col    (ev_col),
    .out_row    (ev_row),
    .out_glyph  (ev_glyph),
    .out_last   (out_tlast)
  );

  // pack fields from the lowest bit up, zero pad to whole bytes
  assign out_tdata = {5'd0, ev_glyph, ev_row, ev_col};

endmodule
